>>> design/assert_macros.svh
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence PIPE_DEPTH register stages on.
`define ASSERT_LATER(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##(hsv2rgb_pkg::PIPE_DEPTH) (cons)) else $error(msg);

`endif

>>> design/hsv2rgb_pkg.sv
// Types, constants and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int HUE_BITS   = 12;
	localparam int LEVEL_BITS = 10;

	// Number of register stages between an accepted beat and its result.
	localparam int PIPE_DEPTH = 5;

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
	localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};
	// LEVEL_MAX * 2^HUE_BITS, the common denominator of q and t.
	localparam logic [LEVEL_BITS+HUE_BITS-1:0] FULL_SCALE = {LEVEL_MAX, {HUE_BITS{1'b0}}};

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_BITS-1:0]   hue;
		logic [LEVEL_BITS-1:0] saturation;
		logic [LEVEL_BITS-1:0] value_level;
	} hsv_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] red_level;
		logic [LEVEL_BITS-1:0] green_level;
		logic [LEVEL_BITS-1:0] blue_level;
	} rgb_t;

	// Divide by 2^LEVEL_BITS - 1 for values up to LEVEL_MAX squared:
	// the high half is the estimate, low half plus high half the remainder,
	// and one correction step settles it.
	function automatic logic [LEVEL_BITS-1:0] div_level_max(
		input logic [2*LEVEL_BITS-1:0] m
	);
		logic [LEVEL_BITS-1:0] hi;
		logic [LEVEL_BITS-1:0] lo;
		logic [LEVEL_BITS:0]   sum;
		logic                  carry;
		hi = m[2*LEVEL_BITS-1:LEVEL_BITS];
		lo = m[LEVEL_BITS-1:0];
		sum = {1'b0, hi} + {1'b0, lo};
		carry = (sum >= {1'b0, LEVEL_MAX});
		return hi + {{(LEVEL_BITS-1){1'b0}}, carry};
	endfunction

endpackage

>>> design/hsv_to_rgb_converter_top.sv
// Top level of the pipelined HSV to RGB converter.

// Converts one HSV color per clock to RGB with the sextant method. A beat is
// taken on every rising edge where start is high; busy stays low, because the
// pipeline never stalls and never has to. Each result appears on rgb for
// exactly one cycle, marked by done, in the same order the beats came in.
// The rate is one color per clock. Each beat passes through five register
// stages: hue times six, the two hue-fraction by saturation products, the
// subtractions from full scale, the products with value, and the divide by
// full level with the sector channel select. Channels are truncated, not
// rounded. Zero saturation gives grey at value_level. The receiver cannot
// hold results off, so it must take each done beat as it comes.
`include "assert_macros.svh"

module hsv_to_rgb_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsv2rgb_pkg::hsv_t hsv,
	output logic              done,
	output hsv2rgb_pkg::rgb_t rgb
);

	localparam int HB = hsv2rgb_pkg::HUE_BITS;
	localparam int LB = hsv2rgb_pkg::LEVEL_BITS;

	// Stage valid bits travel alongside the data.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1: sector, hue fraction and its complement.
	logic [HB+2:0]         h6;
	hsv2rgb_pkg::sector_t  sector_s1;
	logic [HB-1:0]         frac_s1;
	logic [HB:0]           cfrac_s1;
	logic [LB-1:0]         sat_s1, val_s1;

	// Stage 2: fraction products and p numerator term.
	hsv2rgb_pkg::sector_t  sector_s2;
	logic [HB+LB-1:0]      fs_s2;
	logic [HB+LB:0]        cfs_s2;
	logic [LB-1:0]         pd_s2, val_s2;

	// Stage 3: q and t numerator terms.
	hsv2rgb_pkg::sector_t  sector_s3;
	logic [HB+LB-1:0]      xq_s3, xt_s3;
	logic [LB-1:0]         pd_s3, val_s3;

	// Stage 4: products with value.
	hsv2rgb_pkg::sector_t  sector_s4;
	logic [2*LB+HB-1:0]    nq_s4, nt_s4;
	logic [2*LB-1:0]       np_s4;
	logic [LB-1:0]         val_s4;

	// Stage 5 combinational: divide down and pick the channel order.
	logic [LB-1:0]         p_lvl, q_lvl, t_lvl;
	hsv2rgb_pkg::rgb_t     rgb_next;
	hsv2rgb_pkg::rgb_t     rgb_s5;

	// Never stall: the pipeline moves every cycle.
	assign busy = 1'b0;

	assign h6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload stages carry no reset; the valid bits qualify them.
	always_ff @(posedge clk) begin
		sector_s1 <= hsv2rgb_pkg::sector_t'(h6[HB+2:HB]);
		frac_s1   <= h6[HB-1:0];
		cfrac_s1  <= hsv2rgb_pkg::HUE_ONE - {1'b0, h6[HB-1:0]};
		sat_s1    <= hsv.saturation;
		val_s1    <= hsv.value_level;

		sector_s2 <= sector_s1;
		fs_s2     <= frac_s1 * sat_s1;
		cfs_s2    <= cfrac_s1 * sat_s1;
		pd_s2     <= hsv2rgb_pkg::LEVEL_MAX - sat_s1;
		val_s2    <= val_s1;

		sector_s3 <= sector_s2;
		xq_s3     <= hsv2rgb_pkg::FULL_SCALE - fs_s2;
		xt_s3     <= hsv2rgb_pkg::FULL_SCALE - cfs_s2[HB+LB-1:0];
		pd_s3     <= pd_s2;
		val_s3    <= val_s2;

		sector_s4 <= sector_s3;
		nq_s4     <= val_s3 * xq_s3;
		nt_s4     <= val_s3 * xt_s3;
		np_s4     <= val_s3 * pd_s3;
		val_s4    <= val_s3;

		rgb_s5    <= rgb_next;
	end

	// Drop the hue fraction scale by shifting, then divide by full level.
	assign p_lvl = hsv2rgb_pkg::div_level_max(np_s4);
	assign q_lvl = hsv2rgb_pkg::div_level_max(nq_s4[2*LB+HB-1:HB]);
	assign t_lvl = hsv2rgb_pkg::div_level_max(nt_s4[2*LB+HB-1:HB]);

	always_comb begin
		unique case (sector_s4)
			hsv2rgb_pkg::SECTOR_0: rgb_next = '{val_s4, t_lvl, p_lvl};
			hsv2rgb_pkg::SECTOR_1: rgb_next = '{q_lvl, val_s4, p_lvl};
			hsv2rgb_pkg::SECTOR_2: rgb_next = '{p_lvl, val_s4, t_lvl};
			hsv2rgb_pkg::SECTOR_3: rgb_next = '{p_lvl, q_lvl, val_s4};
			hsv2rgb_pkg::SECTOR_4: rgb_next = '{t_lvl, p_lvl, val_s4};
			default:               rgb_next = '{val_s4, p_lvl, q_lvl};
		endcase
	end

	assign done = v_s5;
	assign rgb  = rgb_s5;

	// Every beat comes out exactly once, at the end of the pipeline.
	`ASSERT_LATER(a_beat_gives_result, start, done, "accepted beat produced no result")
	`ASSERT_LATER(a_no_spurious_result, !start, !done, "result without an accepted beat")
	// Zero saturation must come out grey.
	`ASSERT_LATER(a_grey_on_zero_sat, start && (hsv.saturation == '0),
		(rgb.red_level == rgb.green_level) && (rgb.green_level == rgb.blue_level),
		"zero saturation did not give grey")
	// One channel always carries the value level.
	`ASSERT_LATER(a_value_channel, start,
		(rgb.red_level == $past(hsv.value_level, 5)) ||
		(rgb.green_level == $past(hsv.value_level, 5)) ||
		(rgb.blue_level == $past(hsv.value_level, 5)),
		"no channel equals value level")

endmodule
